/* rtl/note_table_tone_sequencer_top_macros.svh */
// Assertion macros shared by the tone sequencer checker.
`ifndef NOTE_TABLE_TONE_SEQUENCER_TOP_MACROS_SVH
`define NOTE_TABLE_TONE_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, idle during reset.
`define NTS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, idle during reset.
`define NTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/nts_pkg.sv */
// Shared constants and types for the note table tone sequencer.
`timescale 1ns / 1ps
package nts_pkg;

   // Default table depth and system clock
   localparam int TABLE_SIZE_DEF = 128;
   localparam longint CLOCK_HZ   = 32000000;

   // Shared divider widths
   localparam int DIV_W = 36;
   localparam int DSR_W = 18;

   // Timer prescaler search
   localparam logic [3:0]  TMR_PS_FIRST = 4'd4;
   localparam logic [3:0]  TMR_PS_LAST  = 4'd15;
   localparam logic [15:0] TICK_MAX     = 16'hFFFF;
   // ceil(2^30 / 125): (x * RECIP_125) >> 30 == x / 125 for any x below 2^23
   localparam logic [23:0] RECIP_125    = 24'd8589935;
   // ticks fit in 16 bits exactly when product < 65536 * 1000
   localparam logic [DIV_W-1:0] TICK_LIMIT = DIV_W'(65536000);
   localparam logic [31:0] CLK_QTR = 32'(CLOCK_HZ / 4);

   // PWM period search
   localparam logic [3:0] PWM_PS_LAST = 4'd8;
   localparam int PER_W = 24;

   // Item operation codes
   localparam logic [2:0] OP_WR_FREQ = 3'd0;
   localparam logic [2:0] OP_WR_DUR  = 3'd1;
   localparam logic [2:0] OP_START   = 3'd2;
   localparam logic [2:0] OP_EXPIRY  = 3'd3;
   localparam logic [2:0] OP_STOP    = 3'd4;

   // Register addresses (byte offsets)
   localparam logic [2:0] REG_NOTE_COUNT = 3'd0;
   localparam logic [2:0] REG_GAP_MS     = 3'd4;

   typedef struct packed {
      logic        tone_enable;
      logic        timer_run;
      logic        pwm_load;
      logic [7:0]  pwm_cycle;
      logic [3:0]  pwm_prescale;
      logic [15:0] pwm_duty;
      logic [15:0] timer_reload;
      logic [3:0]  timer_prescale;
      logic [6:0]  note_position;
      logic        in_gap;
   } nts_result_type;

endpackage

/* rtl/note_table_tone_sequencer_top.sv */
// Tone sequencer top: tables, control sequencer, result register, CSRs.
//
//  channel   dir   handshake        payload
//  req       in    req_valid/ready  operation, slot, value
//  rsp       out   rsp_valid/ready  tone and timer settings
//  csr       in    APB write/read   note_count (0x0), gap_ms (0x4)
//
// Table writes are taken in idle; start and stop build the result, then output it.
// Timer setting: a multiply and a check per prescaler step tried (1 to 12, at most
// 2 for a gap), then the divide by 1000 as a reciprocal multiply.
// Gap beat: timer setting, then output. A note beat adds a table read, the index
// wrap divide (none for a zero note count) and, for a nonzero frequency, the period
// divide and its halving steps. Reset is synchronous; tables are not cleared.
// A new item is taken while a result waits on rsp; its result then stalls input.
`timescale 1ns / 1ps
module note_table_tone_sequencer_top #(
   parameter int TABLE_SIZE = nts_pkg::TABLE_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_slot,
   input  logic [15:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tone_enable,
   output logic        rsp_timer_run,
   output logic        rsp_pwm_load,
   output logic [7:0]  rsp_pwm_cycle,
   output logic [3:0]  rsp_pwm_prescale,
   output logic [15:0] rsp_pwm_duty,
   output logic [15:0] rsp_timer_reload,
   output logic [3:0]  rsp_timer_prescale,
   output logic [6:0]  rsp_note_position,
   output logic        rsp_in_gap,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import nts_pkg::*;

   localparam int AW    = $clog2(TABLE_SIZE);
   localparam int EXT_W = (AW > 8) ? AW : 8;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_READ   = 4'd1;
   localparam logic [3:0] ST_MUL    = 4'd2;
   localparam logic [3:0] ST_CHK    = 4'd3;
   localparam logic [3:0] ST_TDIV   = 4'd4;
   localparam logic [3:0] ST_IDIV   = 4'd5;
   localparam logic [3:0] ST_IWAIT  = 4'd6;
   localparam logic [3:0] ST_PSTART = 4'd7;
   localparam logic [3:0] ST_PDIV   = 4'd8;
   localparam logic [3:0] ST_HALVE  = 4'd9;
   localparam logic [3:0] ST_EMIT   = 4'd10;

   logic [3:0]       state_ff, state_in;
   logic             running_ff, running_in;
   logic             phase_ff, phase_in;
   logic [7:0]       index_ff, index_in;
   logic             in_tbl_ff, in_tbl_in;
   logic [3:0]       tps_ff, tps_in;
   logic [15:0]      delay_ff, delay_in;
   logic [DIV_W-1:0] prod_ff, prod_in;
   logic [15:0]      freq_ff, freq_in;
   logic [PER_W-1:0] period_ff, period_in;
   logic [3:0]       pps_ff, pps_in;
   nts_result_type   res_ff, res_in;
   nts_result_type   out_ff, out_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       note_count_ff;
   logic [7:0]       gap_ms_ff;

   logic             accept;
   logic             csr_wr;
   logic [EXT_W-1:0] slot_ext, index_ext;
   logic             slot_ok, index_ok;
   logic [AW-1:0]    rd_addr;
   logic [15:0]      rd_freq, rd_dur;
   logic [15:0]      dur_w;
   logic [19:0]      kp;
   logic [8:0]       per_inc;
   logic [7:0]       per_clamp;
   logic [46:0]      tick_prod;
   logic [15:0]      ticks;
   logic             div_start;
   logic [DIV_W-1:0] div_dividend;
   logic [DSR_W-1:0] div_divisor;
   logic             div_done;
   logic [DIV_W-1:0] div_quo;
   logic [DSR_W-1:0] div_rem;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // table addressing, range checks at the widest of slot and table index
   assign slot_ext  = EXT_W'(req_slot);
   assign index_ext = EXT_W'(index_ff);
   assign slot_ok   = ({1'b0, slot_ext} < (EXT_W + 1)'(TABLE_SIZE));
   assign index_ok  = ({1'b0, index_ext} < (EXT_W + 1)'(TABLE_SIZE));
   assign rd_addr   = index_ext[AW-1:0];

   nts_table_mem #(.DEPTH(TABLE_SIZE), .AW(AW)) u_freq_mem (
      .clock   (clock),
      .wr_en   (accept && (req_operation == OP_WR_FREQ) && slot_ok),
      .wr_addr (slot_ext[AW-1:0]),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_freq)
   );

   nts_table_mem #(.DEPTH(TABLE_SIZE), .AW(AW)) u_dur_mem (
      .clock   (clock),
      .wr_en   (accept && (req_operation == OP_WR_DUR) && slot_ok),
      .wr_addr (slot_ext[AW-1:0]),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_dur)
   );

   nts_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // helpers for the datapath
   assign dur_w     = in_tbl_ff ? rd_dur : 16'd0;
   assign kp        = 20'(CLK_QTR >> tps_ff);
   // product / 1000 as (product / 8) / 125; a product under the limit is below 2^26
   assign tick_prod = prod_ff[25:3] * RECIP_125;
   assign ticks     = (prod_ff >= TICK_LIMIT) ? TICK_MAX : tick_prod[45:30];
   assign per_clamp = (period_ff > PER_W'(255)) ? 8'd255 : period_ff[7:0];
   assign per_inc   = {1'b0, per_clamp} + 9'd1;

   // control sequencer
   always_comb begin
      state_in     = state_ff;
      running_in   = running_ff;
      phase_in     = phase_ff;
      index_in     = index_ff;
      in_tbl_in    = in_tbl_ff;
      tps_in       = tps_ff;
      delay_in     = delay_ff;
      prod_in      = prod_ff;
      freq_in      = freq_ff;
      period_in    = period_ff;
      pps_in       = pps_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in                = '0;
               res_in.timer_prescale = TMR_PS_FIRST;
               case (req_operation)
                  OP_START: begin
                     index_in            = '0;
                     phase_in            = 1'b0;
                     running_in          = 1'b1;
                     res_in.tone_enable  = 1'b1;
                     res_in.timer_run    = 1'b1;
                     res_in.timer_reload = TICK_MAX;
                     state_in            = ST_EMIT;
                  end
                  OP_STOP: begin
                     running_in = 1'b0;
                     state_in   = ST_EMIT;
                  end
                  OP_EXPIRY: begin
                     if (running_ff) begin
                        res_in.timer_run = 1'b1;
                        tps_in           = TMR_PS_FIRST;
                        if (!phase_ff) begin
                           in_tbl_in = index_ok;
                           state_in  = ST_READ;
                        end else begin
                           phase_in      = 1'b0;
                           delay_in      = {8'd0, gap_ms_ff};
                           res_in.in_gap = 1'b1;
                           state_in      = ST_MUL;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            freq_in              = in_tbl_ff ? rd_freq : 16'd0;
            delay_in             = (dur_w > {8'd0, gap_ms_ff}) ?
                                   dur_w - {8'd0, gap_ms_ff} : 16'd0;
            res_in.note_position = index_ff[6:0];
            phase_in             = 1'b1;
            state_in             = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = DIV_W'(delay_ff) * DIV_W'(kp);
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if ((prod_ff < TICK_LIMIT) || (tps_ff == TMR_PS_LAST)) begin
               state_in = ST_TDIV;
            end else begin
               tps_in   = tps_ff + 4'd1;
               state_in = ST_MUL;
            end
         end
         ST_TDIV: begin
            res_in.timer_reload   = TICK_MAX - ticks;
            res_in.timer_prescale = tps_ff;
            state_in              = res_ff.in_gap ? ST_EMIT : ST_IDIV;
         end
         ST_IDIV: begin
            // next index wraps modulo the note count, to 0 for a zero count
            if (note_count_ff == 8'd0) begin
               index_in = '0;
               state_in = ST_PSTART;
            end else begin
               div_start    = 1'b1;
               div_dividend = DIV_W'({1'b0, index_ff} + 9'd1);
               div_divisor  = DSR_W'(note_count_ff);
               state_in     = ST_IWAIT;
            end
         end
         ST_IWAIT: begin
            if (div_done) begin
               index_in = div_rem[7:0];
               state_in = ST_PSTART;
            end
         end
         ST_PSTART: begin
            if (freq_ff != 16'd0) begin
               div_start    = 1'b1;
               div_dividend = DIV_W'(CLOCK_HZ);
               div_divisor  = {freq_ff, 2'b00};
               state_in     = ST_PDIV;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_PDIV: begin
            if (div_done) begin
               period_in = div_quo[PER_W-1:0];
               pps_in    = '0;
               state_in  = ST_HALVE;
            end
         end
         ST_HALVE: begin
            if ((period_ff > PER_W'(255)) && (pps_ff < PWM_PS_LAST)) begin
               period_in = period_ff >> 1;
               pps_in    = pps_ff + 4'd1;
            end else begin
               // 50% duty: (200 * (period + 1) / 100) << 6
               res_in.tone_enable  = 1'b1;
               res_in.pwm_load     = 1'b1;
               res_in.pwm_cycle    = per_clamp;
               res_in.pwm_prescale = pps_ff;
               res_in.pwm_duty     = {per_inc, 7'd0};
               state_in            = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= 1'b0;
         phase_ff     <= 1'b0;
         index_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         phase_ff     <= phase_in;
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_tbl_ff <= in_tbl_in;
      tps_ff    <= tps_in;
      delay_ff  <= delay_in;
      prod_ff   <= prod_in;
      freq_ff   <= freq_in;
      period_ff <= period_in;
      pps_ff    <= pps_in;
      res_ff    <= res_in;
      out_ff    <= out_in;
   end

   // configuration registers
   assign csr_wr = psel && penable && pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         note_count_ff <= 8'd0;
         gap_ms_ff     <= 8'd1;
      end else if (csr_wr) begin
         if (paddr[2] == REG_GAP_MS[2]) begin
            gap_ms_ff <= pwdata[7:0];
         end else begin
            note_count_ff <= pwdata[7:0];
         end
      end
   end

   assign prdata = (paddr[2] == REG_NOTE_COUNT[2]) ? {24'd0, note_count_ff}
                                                   : {24'd0, gap_ms_ff};
   assign pready = 1'b1;

   // result port
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tone_enable    = out_ff.tone_enable;
   assign rsp_timer_run      = out_ff.timer_run;
   assign rsp_pwm_load       = out_ff.pwm_load;
   assign rsp_pwm_cycle      = out_ff.pwm_cycle;
   assign rsp_pwm_prescale   = out_ff.pwm_prescale;
   assign rsp_pwm_duty       = out_ff.pwm_duty;
   assign rsp_timer_reload   = out_ff.timer_reload;
   assign rsp_timer_prescale = out_ff.timer_prescale;
   assign rsp_note_position  = out_ff.note_position;
   assign rsp_in_gap         = out_ff.in_gap;
endmodule

/* rtl/nts_table_mem.sv */
// Single-port-write, registered-read table memory.
`timescale 1ns / 1ps
module nts_table_mem #(
   parameter int DEPTH = nts_pkg::TABLE_SIZE_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data
);
   import nts_pkg::*;

   logic [15:0] mem_ff [DEPTH];
   logic [15:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/nts_divider.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module nts_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [nts_pkg::DIV_W-1:0]  dividend,
   input  logic [nts_pkg::DSR_W-1:0]  divisor,
   output logic                       done,
   output logic [nts_pkg::DIV_W-1:0]  quotient,
   output logic [nts_pkg::DSR_W-1:0]  remainder
);
   import nts_pkg::*;

   localparam int CW = $clog2(DIV_W);
   localparam logic [CW-1:0] LAST = CW'(DIV_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [DSR_W:0]   trial;
   logic             ge;

   // one shift-subtract step
   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      ge      = (trial >= {1'b0, dsr_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? DSR_W'(trial - {1'b0, dsr_ff}) : trial[DSR_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

/* rtl/nts_checker.sv */
// Port-level checks on the tone sequencer, bound to the top level.
`timescale 1ns / 1ps
`include "note_table_tone_sequencer_top_macros.svh"
module nts_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_tone_enable,
   input logic        rsp_pwm_load,
   input logic [7:0]  rsp_pwm_cycle,
   input logic [15:0] rsp_pwm_duty,
   input logic [3:0]  rsp_timer_prescale,
   input logic        rsp_in_gap,
   input logic        pready
);
   import nts_pkg::*;

   // a waiting beat is not dropped
   `NTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // gap beats are always silent
   `NTS_ASSERT_IMP(a_gap_mute, clock, reset, rsp_valid && rsp_in_gap, !rsp_tone_enable && !rsp_pwm_load)
   // PWM fields are zero unless loaded
   `NTS_ASSERT_IMP(a_pwm_zero, clock, reset, rsp_valid && !rsp_pwm_load, (rsp_pwm_cycle == 8'd0) && (rsp_pwm_duty == 16'd0))
   // timer prescaler never below its first step
   `NTS_ASSERT_IMP(a_tps_min, clock, reset, rsp_valid, rsp_timer_prescale >= TMR_PS_FIRST)
   // register port never waits
   `NTS_ASSERT_IMP(a_pready_hi, clock, reset, 1'b1, pready)
endmodule

bind note_table_tone_sequencer_top nts_checker u_nts_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_tone_enable    (rsp_tone_enable),
   .rsp_pwm_load       (rsp_pwm_load),
   .rsp_pwm_cycle      (rsp_pwm_cycle),
   .rsp_pwm_duty       (rsp_pwm_duty),
   .rsp_timer_prescale (rsp_timer_prescale),
   .rsp_in_gap         (rsp_in_gap),
   .pready             (pready)
);
